// File: hdl/fvn_pkg.sv
`timescale 1ns / 1ps
package fvn_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QUOT_W    = 16;
   localparam int DIV_CNT_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
   localparam logic [31:0] HASH_MUL_S   = 32'd1274126177;
   localparam logic [31:0] HASH_MASK    = 32'h00FF_FFFF;
   localparam logic [31:0] SEED_DEFAULT = 32'd1337;
   localparam logic [16:0] ONE_Q16      = 17'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FREQ  = 2'd3;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_PA    = 10'b00_0000_0010,
      ST_PB    = 10'b00_0000_0100,
      ST_PC    = 10'b00_0000_1000,
      ST_PD    = 10'b00_0001_0000,
      ST_PE    = 10'b00_0010_0000,
      ST_PF    = 10'b00_0100_0000,
      ST_DINIT = 10'b00_1000_0000,
      ST_DIV   = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic step_a;
      logic step_b;
      logic step_c;
      logic step_d;
      logic step_e;
      logic step_f;
      logic div_init;
      logic div_step;
      logic out_write;
   } cmd_type;

endpackage

// File: hdl/fbm_value_noise_2d_unit.sv
`timescale 1ns / 1ps
// one request at a time: req_ready is high only in idle, and each request runs the
// six-step shared octave datapath once per effective octave, then the 16-step
// restoring divide for normalization
// the result register frees the next request while a result waits on rsp_ready
// reset (synchronous, active high) returns to idle and loads the register defaults
module fbm_value_noise_2d_unit import fvn_pkg::*; #(
   parameter int MAX_OCTAVES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [31:0]   req_coord_x,
   input  logic signed [31:0]   req_coord_y,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_noise_value,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   logic [31:0] seed_ff;
   logic [4:0]  octave_count_ff;
   logic [16:0] persistence_ff;
   logic [23:0] base_frequency_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_noise_value_ff;
   logic        rsp_free;
   logic [15:0] noise_value;
   cmd_type     cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff           <= SEED_DEFAULT;
         octave_count_ff   <= 5'd4;
         persistence_ff    <= 17'd32768;
         base_frequency_ff <= 24'd65536;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEED:        seed_ff <= (csr_wdata == '0) ? SEED_DEFAULT : csr_wdata;
            CSR_OCTAVES:     octave_count_ff <= csr_wdata[4:0];
            CSR_PERSISTENCE: persistence_ff <= csr_wdata[16:0];
            CSR_BASE_FREQ:   base_frequency_ff <= csr_wdata[23:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   fvn_ctrl #(
      .MAX_OCTAVES(MAX_OCTAVES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .octave_count (octave_count_ff),
      .rsp_free     (rsp_free),
      .cmd          (cmd)
   );

   fvn_datapath #(
      .MAX_OCTAVES(MAX_OCTAVES)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .seed           (seed_ff),
      .persistence    (persistence_ff),
      .base_frequency (base_frequency_ff),
      .noise_value    (noise_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_write) begin
         rsp_noise_value_ff <= noise_value;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

endmodule

// File: hdl/fvn_ctrl.sv
`timescale 1ns / 1ps
module fvn_ctrl import fvn_pkg::*; #(
   parameter int MAX_OCTAVES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] octave_count,
   input  logic       rsp_free,
   output cmd_type    cmd
);

   localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

   state_type state_ff, state_in;
   logic [OCT_W-1:0] oct_ff, oct_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [5:0] oc_wide;
   logic [OCT_W-1:0] n_eff;

   always_comb begin
      oc_wide = {1'b0, octave_count};
      if (oc_wide == 6'd0) begin
         n_eff = OCT_W'(1);
      end else if (oc_wide > 6'(MAX_OCTAVES)) begin
         n_eff = OCT_W'(MAX_OCTAVES);
      end else begin
         n_eff = OCT_W'(oc_wide);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      oct_in   = oct_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               oct_in   = n_eff;
               state_in = ST_PA;
            end
         end
         ST_PA: begin
            cmd.step_a = 1'b1;
            state_in   = ST_PB;
         end
         ST_PB: begin
            cmd.step_b = 1'b1;
            state_in   = ST_PC;
         end
         ST_PC: begin
            cmd.step_c = 1'b1;
            state_in   = ST_PD;
         end
         ST_PD: begin
            cmd.step_d = 1'b1;
            state_in   = ST_PE;
         end
         ST_PE: begin
            cmd.step_e = 1'b1;
            state_in   = ST_PF;
         end
         ST_PF: begin
            cmd.step_f = 1'b1;
            if (oct_ff == OCT_W'(1)) begin
               state_in = ST_DINIT;
            end else begin
               oct_in   = oct_ff - OCT_W'(1);
               state_in = ST_PA;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.out_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         oct_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         oct_ff   <= oct_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: hdl/fvn_datapath.sv
`timescale 1ns / 1ps
module fvn_datapath import fvn_pkg::*; #(
   parameter int MAX_OCTAVES = 16
) (
   input  logic               clock,
   input  cmd_type            cmd,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic [31:0]        seed,
   input  logic [16:0]        persistence,
   input  logic [23:0]        base_frequency,
   output logic [15:0]        noise_value
);

   localparam int LOG_OCT = $clog2(MAX_OCTAVES);
   localparam int SUM_W   = 41 + LOG_OCT;
   localparam int AMPT_W  = 17 + LOG_OCT;

   function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
                                         input logic [15:0] w);
      logic [40:0] acc;
      acc = 41'(a) * 41'(ONE_Q16 - 17'(w)) + 41'(b) * 41'(w);
      return acc[39:16];
   endfunction

   logic [63:0] px_ff, py_ff;
   logic [31:0] seed_term_ff;
   logic [16:0] pers_ff, amp_ff;
   logic [31:0] mx0_ff, mx1_ff, my0_ff, my1_ff;
   logic [31:0] hm_ff [4];
   logic [31:0] g_ff  [4];
   logic [15:0] t2x_ff, t2y_ff, t3x_ff, t3y_ff, wx_ff, wy_ff;
   logic [20:0] qx_ff, qy_ff;
   logic [23:0] lo_ff, hi_ff, noise_ff;
   logic [SUM_W-1:0] sum_ff, rem_ff, dsh_ff;
   logic [AMPT_W-1:0] ampt_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic ovf_ff;

   logic signed [56:0] prod_x, prod_y;
   logic [31:0] ix, iy;
   logic [15:0] fx, fy;
   logic [31:0] h [4];
   logic [23:0] corner [4];
   logic [SUM_W-1:0] divisor;
   logic [33:0] amp_prod;
   logic [36:0] wx_prod, wy_prod;

   assign prod_x = $signed(req_coord_x) * $signed({1'b0, base_frequency});
   assign prod_y = $signed(req_coord_y) * $signed({1'b0, base_frequency});
   assign ix = px_ff[63:32];
   assign iy = py_ff[63:32];
   assign fx = px_ff[31:16];
   assign fy = py_ff[31:16];

   // corners: 0 (x,y), 1 (x+1,y), 2 (x,y+1), 3 (x+1,y+1)
   assign h[0] = mx0_ff + my0_ff + seed_term_ff;
   assign h[1] = mx1_ff + my0_ff + seed_term_ff;
   assign h[2] = mx0_ff + my1_ff + seed_term_ff;
   assign h[3] = mx1_ff + my1_ff + seed_term_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         corner[c] = 24'((g_ff[c] ^ (g_ff[c] >> 16)) & HASH_MASK);
      end
   end

   assign wx_prod  = 37'(t3x_ff) * 37'(qx_ff);
   assign wy_prod  = 37'(t3y_ff) * 37'(qy_ff);
   assign amp_prod = 34'(amp_ff) * 34'(pers_ff);
   assign divisor  = SUM_W'({ampt_ff, 8'd0});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff        <= {{7{prod_x[56]}}, prod_x};
         py_ff        <= {{7{prod_y[56]}}, prod_y};
         seed_term_ff <= seed * HASH_MUL_S;
         pers_ff      <= (persistence > ONE_Q16) ? ONE_Q16 : persistence;
         amp_ff       <= ONE_Q16;
         ampt_ff      <= '0;
         sum_ff       <= '0;
      end
      if (cmd.step_a) begin
         mx0_ff <= ix * HASH_MUL_X;
         mx1_ff <= (ix + 32'd1) * HASH_MUL_X;
         my0_ff <= iy * HASH_MUL_Y;
         my1_ff <= (iy + 32'd1) * HASH_MUL_Y;
         t2x_ff <= 16'((32'(fx) * 32'(fx)) >> FRAC_BITS);
         t2y_ff <= 16'((32'(fy) * 32'(fy)) >> FRAC_BITS);
      end
      if (cmd.step_b) begin
         for (int c = 0; c < 4; c++) begin
            hm_ff[c] <= h[c] ^ (h[c] >> 13);
         end
         t3x_ff <= 16'((32'(t2x_ff) * 32'(fx)) >> FRAC_BITS);
         t3y_ff <= 16'((32'(t2y_ff) * 32'(fy)) >> FRAC_BITS);
         qx_ff  <= 21'd6 * 21'(t2x_ff) + 21'd655360 - 21'd15 * 21'(fx);
         qy_ff  <= 21'd6 * 21'(t2y_ff) + 21'd655360 - 21'd15 * 21'(fy);
      end
      if (cmd.step_c) begin
         for (int c = 0; c < 4; c++) begin
            g_ff[c] <= hm_ff[c] * HASH_MUL_S;
         end
         wx_ff <= wx_prod[31:16];
         wy_ff <= wy_prod[31:16];
      end
      if (cmd.step_d) begin
         lo_ff <= blend(corner[0], corner[1], wx_ff);
         hi_ff <= blend(corner[2], corner[3], wx_ff);
      end
      if (cmd.step_e) begin
         noise_ff <= blend(lo_ff, hi_ff, wy_ff);
      end
      if (cmd.step_f) begin
         sum_ff  <= sum_ff + SUM_W'(41'(noise_ff) * 41'(amp_ff));
         ampt_ff <= ampt_ff + AMPT_W'(amp_ff);
         amp_ff  <= amp_prod[32:16];
         px_ff   <= {px_ff[62:0], 1'b0};
         py_ff   <= {py_ff[62:0], 1'b0};
      end
      if (cmd.div_init) begin
         rem_ff  <= sum_ff;
         dsh_ff  <= divisor << (QUOT_W - 1);
         ovf_ff  <= (sum_ff >= (divisor << QUOT_W));
         quot_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff  <= rem_ff - dsh_ff;
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign noise_value = ovf_ff ? '1 : quot_ff;

endmodule
